>>> design/vcg_pkg.sv
// ----------------------------------------------------------------------------
// vcg_pkg
// Shared types, codes and constants of the Verlet cloth grid engine.
// ----------------------------------------------------------------------------
package vcg_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_GRAVITY = 3'd0;
    localparam logic [2:0] CFG_PASSES  = 3'd1;
    localparam logic [2:0] CFG_SPACING = 3'd2;
    localparam logic [2:0] CFG_ORIG_X  = 3'd3;
    localparam logic [2:0] CFG_ORIG_Y  = 3'd4;

    // Register reset values
    localparam logic [25:0] GRAVITY_RST = 26'd32768000;
    localparam logic [3:0]  PASSES_RST  = 4'd5;
    localparam logic [22:0] SPACING_RST = 23'd1310720;
    localparam logic [28:0] ORIG_X_RST  = 29'd19660800;
    localparam logic [28:0] ORIG_Y_RST  = 29'd6553600;

    // Time step ceiling, 0.02 s in Q16.16
    localparam logic [10:0] DT_MAX = 11'd1311;

    // Iteration counts of the shared unit
    localparam logic [5:0] SQRT_STEPS = 6'd32;
    localparam logic [5:0] DIV_STEPS  = 6'd34;

    // Command codes, also the completion codes
    typedef enum logic [1:0] {
        ACT_STEP    = 2'd0,
        ACT_READ    = 2'd1,
        ACT_REBUILD = 2'd2
    } t_action;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_SQRT = 2'd1,
        ALU_DIV  = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    // Store write enables
    typedef struct packed {
        logic cur_we;
        logic prev_we;
    } t_store_wr;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE,
        ST_LAY,
        ST_RD_ADDR,
        ST_RD_OUT,
        ST_G_DT,
        ST_G_DTW,
        ST_G_MUL,
        ST_G_MULW,
        ST_V_ADDR,
        ST_V_UPD,
        ST_L_SEL,
        ST_L_RDA,
        ST_L_RDB,
        ST_L_LATB,
        ST_L_DELTA,
        ST_L_SQX,
        ST_L_SQXW,
        ST_L_SQY,
        ST_L_SQYW,
        ST_L_ROOT,
        ST_L_ROOTW,
        ST_L_DIFF,
        ST_L_MX,
        ST_L_MXW,
        ST_L_DX,
        ST_L_DXW,
        ST_L_MY,
        ST_L_MYW,
        ST_L_DY,
        ST_L_DYW,
        ST_L_WRA,
        ST_L_WRB,
        ST_L_NEXT
    } t_state;

    // Clamp to signed 32 bit
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> design/vcg_alu.sv
// ----------------------------------------------------------------------------
// vcg_alu
// Shared arithmetic unit: registered 32x32 multiply, bit-pair integer square
// root of a 64 bit value, and restoring divide with a 34 bit quotient.
// ----------------------------------------------------------------------------
module vcg_alu import vcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_ctl    i_ctl,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_res,
    output logic        o_done
);

    logic        r_busy;
    logic        r_done;
    t_alu_op     r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_acc;
    logic [63:0] r_aux;
    logic [63:0] r_res;
    logic [32:0] r_den;

    logic [63:0] sq_trial;
    logic [33:0] dv_shift;

    assign sq_trial = r_res + r_aux;
    assign dv_shift = {r_acc[32:0], r_aux[63]};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= (i_ctl.op != ALU_MUL);
                r_done <= (i_ctl.op == ALU_MUL);
                r_cnt  <= (i_ctl.op == ALU_DIV) ? DIV_STEPS : SQRT_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op <= i_ctl.op;
            unique case (i_ctl.op)
                ALU_MUL: begin
                    r_res <= i_a[31:0] * i_b[31:0];
                end
                ALU_SQRT: begin
                    r_acc <= i_a;
                    r_res <= '0;
                    r_aux <= 64'h4000_0000_0000_0000;
                end
                ALU_DIV: begin
                    // quotient is known to fit 34 bits
                    r_acc <= {34'd0, i_a[63:34]};
                    r_aux <= {i_a[33:0], 30'd0};
                    r_den <= i_b[32:0];
                    r_res <= '0;
                end
                default: begin
                    r_res <= '0;
                end
            endcase
        end else if (r_busy) begin
            unique case (r_op)
                ALU_SQRT: begin
                    if (r_acc >= sq_trial) begin
                        r_acc <= r_acc - sq_trial;
                        r_res <= (r_res >> 1) + r_aux;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_aux <= r_aux >> 2;
                end
                ALU_DIV: begin
                    if (dv_shift >= {1'b0, r_den}) begin
                        r_acc <= {30'd0, dv_shift - {1'b0, r_den}};
                        r_res <= {r_res[62:0], 1'b1};
                    end else begin
                        r_acc <= {30'd0, dv_shift};
                        r_res <= {r_res[62:0], 1'b0};
                    end
                    r_aux <= r_aux << 1;
                end
                default: begin
                    r_res <= r_res;
                end
            endcase
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

>>> design/vcg_store.sv
// ----------------------------------------------------------------------------
// vcg_store
// Point store: current and previous X/Y per point, one shared read address
// with registered data, one write address.
// ----------------------------------------------------------------------------
module vcg_store import vcg_pkg::*; #(
    parameter int DEPTH = 180,
    parameter int AW    = 8
) (
    input  logic                 i_clk,
    input  logic [AW-1:0]        i_rd_addr,
    input  t_store_wr            i_wr,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic signed [31:0]   i_cx,
    input  logic signed [31:0]   i_cy,
    input  logic signed [31:0]   i_px,
    input  logic signed [31:0]   i_py,
    output logic signed [31:0]   o_cx,
    output logic signed [31:0]   o_cy,
    output logic signed [31:0]   o_px,
    output logic signed [31:0]   o_py
);

    logic signed [31:0] cur_x  [DEPTH];
    logic signed [31:0] cur_y  [DEPTH];
    logic signed [31:0] prev_x [DEPTH];
    logic signed [31:0] prev_y [DEPTH];

    // Writes
    always_ff @(posedge i_clk) begin
        if (i_wr.cur_we) begin
            cur_x[i_wr_addr] <= i_cx;
            cur_y[i_wr_addr] <= i_cy;
        end
        if (i_wr.prev_we) begin
            prev_x[i_wr_addr] <= i_px;
            prev_y[i_wr_addr] <= i_py;
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        o_cx <= cur_x[i_rd_addr];
        o_cy <= cur_y[i_rd_addr];
        o_px <= prev_x[i_rd_addr];
        o_py <= prev_y[i_rd_addr];
    end

endmodule

>>> design/verlet_cloth_grid_step.sv
// ----------------------------------------------------------------------------
// verlet_cloth_grid_step
// Cloth grid of Q16.16 points: Verlet step with gravity, link relaxation,
// point read-back and lattice rebuild, all under one sequencer.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the cycle in which the command's result is shown for one cycle on
// o_done, which the receiver must take as it comes; that same cycle can
// already take the next command. After reset the block lays the default
// lattice, one point a cycle, while busy is high. A read sets the store
// address and then registers the point; a rebuild lays the lattice anew
// from the registers. A step forms the gravity term in the shared unit,
// integrates every point below the top row, then relaxes each link once per
// pass with a 32-step square root and two 34-step divides in the shared
// unit per link; a zero-length link skips the divides and its writes.
// ----------------------------------------------------------------------------
module verlet_cloth_grid_step import vcg_pkg::*; #(
    parameter int GRID_COLUMNS = 15,
    parameter int GRID_ROWS    = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [10:0]        i_step_time,
    input  logic [7:0]         i_point_index,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [28:0]        i_cfg_wdata,
    output logic               o_done,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_point_fixed,
    output logic [7:0]         o_echo_index,
    output logic [1:0]         o_completion
);

    localparam int NPTS = GRID_COLUMNS * GRID_ROWS;
    localparam int AW   = $clog2(NPTS);
    localparam int CW   = $clog2(GRID_COLUMNS);
    localparam int RW   = $clog2(GRID_ROWS);

    // Configuration registers
    logic [25:0] r_grav;
    logic [3:0]  r_passes;
    logic [22:0] r_space;
    logic [28:0] r_orig_x;
    logic [28:0] r_orig_y;

    // Sequencer
    t_state r_state, n_state;
    logic [AW-1:0] r_k;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_vert;
    logic [3:0]    r_pass;
    logic          r_lay_rst;

    // Lattice laying
    logic [31:0] r_lay_ox;
    logic [31:0] r_lay_sp;
    logic [31:0] r_lx;
    logic [31:0] r_ly;

    // Working registers
    logic [10:0]        r_dt;
    logic [16:0]        r_g;
    logic [7:0]         r_idx;
    logic signed [31:0] r_xa, r_ya, r_xb, r_yb;
    logic [31:0]        r_ax, r_ay;
    logic               r_nx, r_ny, r_dneg;
    logic [63:0]        r_sq;
    logic [31:0]        r_len;
    logic [31:0]        r_ad;
    logic signed [34:0] r_ox, r_oy;

    // Result registers
    logic               r_done;
    logic signed [31:0] r_px, r_py;
    logic               r_pfix;
    logic [7:0]         r_echo;
    t_action            r_comp;

    // Store and shared unit connections
    logic [AW-1:0]      st_rd_addr, st_wr_addr;
    t_store_wr          st_wr;
    logic signed [31:0] st_wcx, st_wcy, st_wpx, st_wpy;
    logic signed [31:0] st_cx, st_cy, st_px, st_py;
    t_alu_ctl           alu_ctl;
    logic [63:0]        alu_a, alu_b, alu_res;
    logic               alu_done;

    vcg_store #(.DEPTH(NPTS), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (st_rd_addr),
        .i_wr      (st_wr),
        .i_wr_addr (st_wr_addr),
        .i_cx      (st_wcx),
        .i_cy      (st_wcy),
        .i_px      (st_wpx),
        .i_py      (st_wpy),
        .o_cx      (st_cx),
        .o_cy      (st_cy),
        .o_px      (st_px),
        .o_py      (st_py)
    );

    vcg_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_done  (alu_done)
    );

    // Common decodes
    logic          accept;
    logic          col_last, row_last, pt_last, pass_last, lay_last;
    logic [AW-1:0] b_idx;
    logic [15:0]   idx_w;
    logic          idx_ok;

    assign accept    = start && !busy;
    assign col_last  = (r_col == CW'(GRID_COLUMNS - 1));
    assign row_last  = (r_row == RW'(GRID_ROWS - 1));
    assign pt_last   = (r_k == AW'(NPTS - 1));
    assign lay_last  = pt_last;
    assign pass_last = (r_pass == (r_passes - 4'd1));
    assign b_idx     = r_vert ? (r_k + AW'(GRID_COLUMNS)) : (r_k + AW'(1));
    assign idx_w     = {8'd0, r_idx};
    assign idx_ok    = (idx_w < 16'(NPTS));
    assign busy      = (r_state != ST_IDLE);

    // Integration arithmetic
    logic signed [39:0] v_vx, v_vy;
    logic signed [31:0] v_nx, v_ny;
    assign v_vx = 40'(st_cx) - 40'(st_px);
    assign v_vy = 40'(st_cy) - 40'(st_py);
    assign v_nx = sat32(40'(st_cx) + v_vx);
    assign v_ny = sat32(40'(st_cy) + v_vy + 40'({1'b0, r_g}));

    // Link arithmetic
    logic signed [31:0] l_dx, l_dy;
    logic signed [33:0] l_diff;
    logic [33:0]        l_q;
    assign l_dx   = sat32(40'(r_xb) - 40'(r_xa));
    assign l_dy   = sat32(40'(r_yb) - 40'(r_ya));
    assign l_diff = $signed({2'b00, r_len}) - $signed({11'd0, r_space});
    assign l_q    = alu_res[33:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_action'(i_action))
                        ACT_STEP:    n_state = ST_G_DT;
                        ACT_READ:    n_state = ST_RD_ADDR;
                        ACT_REBUILD: n_state = ST_LAY;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LAY:     if (lay_last) n_state = ST_IDLE;
            ST_RD_ADDR: n_state = ST_RD_OUT;
            ST_RD_OUT:  n_state = ST_IDLE;
            ST_G_DT:    n_state = ST_G_DTW;
            ST_G_DTW:   if (alu_done) n_state = ST_G_MUL;
            ST_G_MUL:   n_state = ST_G_MULW;
            ST_G_MULW:  if (alu_done) n_state = ST_V_ADDR;
            ST_V_ADDR:  n_state = ST_V_UPD;
            ST_V_UPD: begin
                if (!pt_last) begin
                    n_state = ST_V_ADDR;
                end else if (r_passes == 4'd0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_L_SEL;
                end
            end
            ST_L_SEL: begin
                priority if (!r_vert && !col_last) begin
                    n_state = ST_L_RDA;
                end else if (!r_vert) begin
                    n_state = ST_L_SEL;
                end else if (!row_last) begin
                    n_state = ST_L_RDA;
                end else if (pt_last && pass_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_L_SEL;
                end
            end
            ST_L_RDA:   n_state = ST_L_RDB;
            ST_L_RDB:   n_state = ST_L_LATB;
            ST_L_LATB:  n_state = ST_L_DELTA;
            ST_L_DELTA: n_state = ST_L_SQX;
            ST_L_SQX:   n_state = ST_L_SQXW;
            ST_L_SQXW:  if (alu_done) n_state = ST_L_SQY;
            ST_L_SQY:   n_state = ST_L_SQYW;
            ST_L_SQYW:  if (alu_done) n_state = ST_L_ROOT;
            ST_L_ROOT:  n_state = ST_L_ROOTW;
            ST_L_ROOTW: begin
                if (alu_done) begin
                    n_state = (alu_res == 64'd0) ? ST_L_NEXT : ST_L_DIFF;
                end
            end
            ST_L_DIFF:  n_state = ST_L_MX;
            ST_L_MX:    n_state = ST_L_MXW;
            ST_L_MXW:   if (alu_done) n_state = ST_L_DX;
            ST_L_DX:    n_state = ST_L_DXW;
            ST_L_DXW:   if (alu_done) n_state = ST_L_MY;
            ST_L_MY:    n_state = ST_L_MYW;
            ST_L_MYW:   if (alu_done) n_state = ST_L_DY;
            ST_L_DY:    n_state = ST_L_DYW;
            ST_L_DYW:   if (alu_done) n_state = ST_L_WRA;
            ST_L_WRA:   n_state = ST_L_WRB;
            ST_L_WRB:   n_state = ST_L_NEXT;
            ST_L_NEXT: begin
                if (r_vert && pt_last && pass_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_L_SEL;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Store and shared unit controls
    always_comb begin
        st_rd_addr    = r_k;
        st_wr_addr    = r_k;
        st_wr         = '0;
        st_wcx        = v_nx;
        st_wcy        = v_ny;
        st_wpx        = st_cx;
        st_wpy        = st_cy;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = ALU_MUL;
        alu_a         = '0;
        alu_b         = '0;
        unique case (r_state)
            ST_LAY: begin
                st_wr  = '{cur_we: 1'b1, prev_we: 1'b1};
                st_wcx = r_lx;
                st_wcy = r_ly;
                st_wpx = r_lx;
                st_wpy = r_ly;
            end
            ST_RD_ADDR: st_rd_addr = idx_w[AW-1:0];
            ST_V_UPD:   st_wr = '{cur_we: 1'b1, prev_we: 1'b1};
            ST_L_RDB:   st_rd_addr = b_idx;
            ST_G_DT: begin
                alu_ctl = '{start: 1'b1, op: ALU_MUL};
                alu_a   = {53'd0, r_dt};
                alu_b   = {53'd0, r_dt};
            end
            ST_G_MUL: begin
                alu_ctl = '{start: 1'b1, op: ALU_MUL};
                alu_a   = alu_res;
                alu_b   = {38'd0, r_grav};
            end
            ST_L_SQX: begin
                alu_ctl = '{start: 1'b1, op: ALU_MUL};
                alu_a   = {32'd0, r_ax};
                alu_b   = {32'd0, r_ax};
            end
            ST_L_SQY: begin
                alu_ctl = '{start: 1'b1, op: ALU_MUL};
                alu_a   = {32'd0, r_ay};
                alu_b   = {32'd0, r_ay};
            end
            ST_L_ROOT: begin
                alu_ctl = '{start: 1'b1, op: ALU_SQRT};
                alu_a   = r_sq;
            end
            ST_L_MX: begin
                alu_ctl = '{start: 1'b1, op: ALU_MUL};
                alu_a   = {32'd0, r_ax};
                alu_b   = {32'd0, r_ad};
            end
            ST_L_MY: begin
                alu_ctl = '{start: 1'b1, op: ALU_MUL};
                alu_a   = {32'd0, r_ay};
                alu_b   = {32'd0, r_ad};
            end
            ST_L_DX, ST_L_DY: begin
                // (mag + len) / (2 * len), rounds half away from zero
                alu_ctl = '{start: 1'b1, op: ALU_DIV};
                alu_a   = alu_res + {32'd0, r_len};
                alu_b   = {31'd0, r_len, 1'b0};
            end
            ST_L_WRA: begin
                st_wr.cur_we = (r_row != '0);
                st_wcx       = sat32(40'(r_xa) + 40'(r_ox));
                st_wcy       = sat32(40'(r_ya) + 40'(r_oy));
            end
            ST_L_WRB: begin
                st_wr.cur_we = r_vert || (r_row != '0);
                st_wr_addr   = b_idx;
                st_wcx       = sat32(40'(r_xb) - 40'(r_ox));
                st_wcy       = sat32(40'(r_yb) - 40'(r_oy));
            end
            default: begin
                st_wr = '0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav   <= GRAVITY_RST;
            r_passes <= PASSES_RST;
            r_space  <= SPACING_RST;
            r_orig_x <= ORIG_X_RST;
            r_orig_y <= ORIG_Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRAVITY: r_grav   <= i_cfg_wdata[25:0];
                CFG_PASSES:  r_passes <= i_cfg_wdata[3:0];
                CFG_SPACING: r_space  <= i_cfg_wdata[22:0];
                CFG_ORIG_X:  r_orig_x <= i_cfg_wdata;
                CFG_ORIG_Y:  r_orig_y <= i_cfg_wdata;
                default:     r_grav   <= r_grav;
            endcase
        end
    end

    // Sequencer registers, walk counters and lattice laying
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LAY;
            r_lay_rst <= 1'b1;
            r_k       <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_vert    <= 1'b0;
            r_pass    <= '0;
            r_lay_ox  <= {3'd0, ORIG_X_RST};
            r_lay_sp  <= {9'd0, SPACING_RST};
            r_lx      <= {3'd0, ORIG_X_RST};
            r_ly      <= {3'd0, ORIG_Y_RST};
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_lay_rst <= 1'b0;
                        r_k       <= '0;
                        r_col     <= '0;
                        r_row     <= '0;
                        r_lay_ox  <= {3'd0, r_orig_x};
                        r_lay_sp  <= {9'd0, r_space};
                        r_lx      <= {3'd0, r_orig_x};
                        r_ly      <= {3'd0, r_orig_y};
                    end
                end
                ST_LAY: begin
                    r_k <= r_k + AW'(1);
                    if (col_last) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                        r_lx  <= r_lay_ox;
                        r_ly  <= r_ly + r_lay_sp;
                    end else begin
                        r_col <= r_col + CW'(1);
                        r_lx  <= r_lx + r_lay_sp;
                    end
                end
                ST_G_MULW: r_k <= AW'(GRID_COLUMNS);
                ST_V_UPD: begin
                    if (pt_last) begin
                        r_k    <= '0;
                        r_col  <= '0;
                        r_row  <= '0;
                        r_vert <= 1'b0;
                        r_pass <= '0;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                ST_L_SEL, ST_L_NEXT: begin
                    if (!r_vert) begin
                        if (r_state == ST_L_NEXT || col_last) begin
                            r_vert <= 1'b1;
                        end
                    end else if (r_state == ST_L_NEXT || row_last) begin
                        // move to the next point
                        r_vert <= 1'b0;
                        if (pt_last) begin
                            r_k    <= '0;
                            r_col  <= '0;
                            r_row  <= '0;
                            r_pass <= r_pass + 4'd1;
                        end else begin
                            r_k <= r_k + AW'(1);
                            if (col_last) begin
                                r_col <= '0;
                                r_row <= r_row + RW'(1);
                            end else begin
                                r_col <= r_col + CW'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_pass <= r_pass;
                end
            endcase
        end
    end

    // Working datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_dt  <= (i_step_time > DT_MAX) ? DT_MAX : i_step_time;
                r_idx <= i_point_index;
            end
            ST_G_MULW: r_g <= 17'((alu_res + 64'h8000_0000) >> 32);
            ST_L_RDB: begin
                r_xa <= st_cx;
                r_ya <= st_cy;
            end
            ST_L_LATB: begin
                r_xb <= st_cx;
                r_yb <= st_cy;
            end
            ST_L_DELTA: begin
                r_nx <= l_dx[31];
                r_ny <= l_dy[31];
                r_ax <= l_dx[31] ? 32'(-l_dx) : 32'(l_dx);
                r_ay <= l_dy[31] ? 32'(-l_dy) : 32'(l_dy);
            end
            ST_L_SQXW:  r_sq  <= alu_res;
            ST_L_SQYW:  r_sq  <= r_sq + alu_res;
            ST_L_ROOTW: r_len <= alu_res[31:0];
            ST_L_DIFF: begin
                r_dneg <= l_diff[33];
                r_ad   <= l_diff[33] ? 32'(-l_diff) : l_diff[31:0];
            end
            ST_L_DXW: begin
                r_ox <= (r_nx ^ r_dneg) ? -$signed({1'b0, l_q}) : $signed({1'b0, l_q});
            end
            ST_L_DYW: begin
                r_oy <= (r_ny ^ r_dneg) ? -$signed({1'b0, l_q}) : $signed({1'b0, l_q});
            end
            default: begin
                r_g <= r_g;
            end
        endcase
    end

    // Result transfer, a one-cycle done pulse per completed command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_px   <= '0;
            r_py   <= '0;
            r_pfix <= 1'b0;
            r_echo <= '0;
            unique case (r_state)
                ST_LAY: begin
                    if (lay_last && !r_lay_rst) begin
                        r_done <= 1'b1;
                        r_comp <= ACT_REBUILD;
                    end
                end
                ST_RD_OUT: begin
                    r_done <= 1'b1;
                    r_comp <= ACT_READ;
                    if (idx_ok) begin
                        r_px   <= st_cx;
                        r_py   <= st_cy;
                        r_pfix <= (idx_w < 16'(GRID_COLUMNS));
                        r_echo <= r_idx;
                    end
                end
                ST_V_UPD, ST_L_SEL, ST_L_NEXT: begin
                    if (r_state != ST_IDLE && n_state == ST_IDLE) begin
                        r_done <= 1'b1;
                        r_comp <= ACT_STEP;
                    end
                end
                default: begin
                    r_done <= 1'b0;
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_point_x     = r_px;
    assign o_point_y     = r_py;
    assign o_point_fixed = r_pfix;
    assign o_echo_index  = r_echo;
    assign o_completion  = r_comp;

endmodule

>>> bench/tb_verlet_cloth_grid_step.sv
// ----------------------------------------------------------------------------
// tb_verlet_cloth_grid_step
// Self-checking bench for the cloth grid engine. A directed table walks the
// reset lattice, out-of-range reads, the unused command, rebuild and a step
// with a saturated time step. Random commands then run under several register
// settings. Every result is checked against a table row or a local model of the grid.
// ----------------------------------------------------------------------------
module tb_verlet_cloth_grid_step import vcg_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS    = 15;
    localparam int ROWS    = 12;
    localparam int NPTS    = COLS * ROWS;
    localparam int LIMIT   = 5000000;
    localparam int SETTLE  = 400;
    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        fixed;
        logic [7:0]  echo;
        logic [1:0]  comp;
    } t_point_res;

    typedef struct {
        logic [1:0]  act;
        logic [10:0] dt;
        logic [7:0]  idx;
        bit          lit;
        t_point_res  res;
    } t_cmd_row;

    // DUT signals
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_action = '0;
    logic [10:0]        i_step_time = '0;
    logic [7:0]         i_point_index = '0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [28:0]        i_cfg_wdata = '0;
    logic               o_done;
    logic signed [31:0] o_point_x;
    logic signed [31:0] o_point_y;
    logic               o_point_fixed;
    logic [7:0]         o_echo_index;
    logic [1:0]         o_completion;

    // Model state and registers
    logic signed [31:0] cloth_x [NPTS];
    logic signed [31:0] cloth_y [NPTS];
    logic signed [31:0] last_x  [NPTS];
    logic signed [31:0] last_y  [NPTS];
    logic [25:0] m_gravity;
    logic [3:0]  m_passes;
    logic [22:0] m_spacing;
    logic [28:0] m_orig_x;
    logic [28:0] m_orig_y;

    t_point_res pending_points[$];
    int errors = 0;
    int checked = 0;
    int n_step = 0, n_read = 0, n_rebuild = 0, n_none = 0;
    int cycles = 0;
    int burst_left = 0;

    verlet_cloth_grid_step #(.GRID_COLUMNS(COLS), .GRID_ROWS(ROWS)) uut (.*);

    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic longint half_pull(input longint unsigned mag, input bit neg,
                                         input longint unsigned len);
        longint unsigned q;
        q = (mag + len) / (2 * len);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void lay_grid();
        int k;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                k = r * COLS + c;
                cloth_x[k] = clamp32(longint'(m_orig_x) + longint'(c) * m_spacing);
                cloth_y[k] = clamp32(longint'(m_orig_y) + longint'(r) * m_spacing);
                last_x[k] = cloth_x[k];
                last_y[k] = cloth_y[k];
            end
        end
    endfunction

    // Pull both ends of one link halfway toward rest length
    function automatic void pull_link(input int a, input int b);
        longint dx, dy, diff, ox, oy;
        longint unsigned ax, ay, len, ad;
        dx = clamp32(longint'(cloth_x[b]) - cloth_x[a]);
        dy = clamp32(longint'(cloth_y[b]) - cloth_y[a]);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        len = root_floor(ax * ax + ay * ay);
        if (len == 0) return;  // coincident ends: link skipped
        diff = longint'(len) - longint'(m_spacing);
        ad = diff < 0 ? -diff : diff;
        ox = half_pull(ax * ad, (dx < 0) != (diff < 0), len);
        oy = half_pull(ay * ad, (dy < 0) != (diff < 0), len);
        if (a >= COLS) begin
            cloth_x[a] = clamp32(longint'(cloth_x[a]) + ox);
            cloth_y[a] = clamp32(longint'(cloth_y[a]) + oy);
        end
        if (b >= COLS) begin
            cloth_x[b] = clamp32(longint'(cloth_x[b]) - ox);
            cloth_y[b] = clamp32(longint'(cloth_y[b]) - oy);
        end
    endfunction

    function automatic void advance_cloth(input logic [10:0] dt_in);
        longint unsigned dt, g;
        longint vx, vy;
        int k;
        dt = (dt_in > DT_MAX) ? DT_MAX : dt_in;
        g = (longint'(m_gravity) * dt * dt + (64'd1 << 31)) >> 32;
        for (k = COLS; k < NPTS; k++) begin
            vx = longint'(cloth_x[k]) - last_x[k];
            vy = longint'(cloth_y[k]) - last_y[k];
            last_x[k] = cloth_x[k];
            last_y[k] = cloth_y[k];
            cloth_x[k] = clamp32(longint'(cloth_x[k]) + vx);
            cloth_y[k] = clamp32(longint'(cloth_y[k]) + vy + longint'(g));
        end
        for (int p = 0; p < m_passes; p++) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    k = r * COLS + c;
                    if (c < COLS - 1) pull_link(k, k + 1);
                    if (r < ROWS - 1) pull_link(k, k + COLS);
                end
            end
        end
    endfunction

    // Apply one command to the model; returns 0 when no result follows
    function automatic bit grid_command(input logic [1:0] act, input logic [10:0] dt,
                                        input logic [7:0] idx, output t_point_res res);
        res = '{x: '0, y: '0, fixed: 1'b0, echo: '0, comp: act};
        case (act)
            ACT_STEP: begin
                advance_cloth(dt);
                n_step++;
            end
            ACT_READ: begin
                if (idx < NPTS) begin
                    res.x = cloth_x[idx];
                    res.y = cloth_y[idx];
                    res.fixed = (idx < COLS);
                    res.echo = idx;
                end
                n_read++;
            end
            ACT_REBUILD: begin
                lay_grid();
                n_rebuild++;
            end
            default: begin
                n_none++;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // Queue one expected result at the tail
    function automatic void expect_result(input t_point_res r);
        pending_points.insert(pending_points.size(), r);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%08h expected 0x%08h", what, got, want);
        errors++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_point_res want;
        if (i_rst_n && o_done) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected result", {30'd0, o_completion}, 32'd0);
            end else begin
                want = pending_points.pop_front();
                checked++;
                if (o_completion !== want.comp)
                    report_mismatch("completion", 32'(o_completion), 32'(want.comp));
                if (o_point_x !== want.x) report_mismatch("point_x", o_point_x, want.x);
                if (o_point_y !== want.y) report_mismatch("point_y", o_point_y, want.y);
                if (o_point_fixed !== want.fixed)
                    report_mismatch("point_fixed", 32'(o_point_fixed), 32'(want.fixed));
                if (o_echo_index !== want.echo)
                    report_mismatch("echo_index", 32'(o_echo_index), 32'(want.echo));
            end
        end
    end

    // Issue one command in bursts; returns at the edge of its transfer
    task automatic issue_cmd(input logic [1:0] act, input logic [10:0] dt,
                             input logic [7:0] idx, input bit lit, input t_point_res lit_res);
        int gap;
        t_point_res res;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        start <= 1'b1;
        i_action <= act;
        i_step_time <= dt;
        i_point_index <= idx;
        do @(posedge i_clk); while (busy);
        burst_left--;
        if (grid_command(act, dt, idx, res)) expect_result(lit ? lit_res : res);
    endtask

    // Let every expected result arrive, then settle
    task automatic drain_results();
        start <= 1'b0;
        burst_left = 0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One register write, also applied to the model registers
    task automatic cfg_write(input logic [2:0] idx, input logic [28:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GRAVITY: m_gravity = data[25:0];
            CFG_PASSES:  m_passes = data[3:0];
            CFG_SPACING: m_spacing = data[22:0];
            CFG_ORIG_X:  m_orig_x = data;
            CFG_ORIG_Y:  m_orig_y = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic random_cmds(input int count, input int step_pct);
        logic [1:0] act;
        logic [7:0] idx;
        int pick;
        t_point_res none;
        none = '{x: '0, y: '0, fixed: 1'b0, echo: '0, comp: '0};
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < step_pct) act = ACT_STEP;
            else if (pick < 90) act = ACT_READ;
            else if (pick < 96) act = ACT_REBUILD;
            else act = ACT_NONE;
            idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, NPTS - 1));
            issue_cmd(act, 11'($urandom_range(0, 2047)), idx, 1'b0, none);
        end
    endtask

    t_cmd_row table_rows[] = '{
        '{ACT_READ, 11'd0, 8'd0, 1'b1, '{32'd19660800, 32'd6553600, 1'b1, 8'd0, ACT_READ}},
        '{ACT_READ, 11'd0, 8'd14, 1'b1, '{32'd38010880, 32'd6553600, 1'b1, 8'd14, ACT_READ}},
        '{ACT_READ, 11'd0, 8'd15, 1'b1, '{32'd19660800, 32'd7864320, 1'b0, 8'd15, ACT_READ}},
        '{ACT_READ, 11'd0, 8'd179, 1'b1,
          '{32'd38010880, 32'd20971520, 1'b0, 8'd179, ACT_READ}},
        '{ACT_READ, 11'd0, 8'd180, 1'b1, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_READ}},
        '{ACT_READ, 11'd0, 8'd255, 1'b1, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_READ}},
        '{ACT_NONE, 11'd2047, 8'd255, 1'b0, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_READ}},
        '{ACT_REBUILD, 11'd0, 8'd0, 1'b1, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_REBUILD}},
        // time step far above the ceiling saturates
        '{ACT_STEP, 11'd2047, 8'd0, 1'b1, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_STEP}},
        '{ACT_READ, 11'd0, 8'd7, 1'b0, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_READ}},
        '{ACT_READ, 11'd0, 8'd15, 1'b0, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_READ}},
        '{ACT_READ, 11'd0, 8'd97, 1'b0, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_READ}},
        '{ACT_READ, 11'd0, 8'd179, 1'b0, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_READ}},
        '{ACT_REBUILD, 11'd0, 8'd0, 1'b1, '{32'd0, 32'd0, 1'b0, 8'd0, ACT_REBUILD}},
        '{ACT_READ, 11'd0, 8'd179, 1'b1,
          '{32'd38010880, 32'd20971520, 1'b0, 8'd179, ACT_READ}}
    };

    // Main sequence
    initial begin
        m_gravity = GRAVITY_RST;
        m_passes = PASSES_RST;
        m_spacing = SPACING_RST;
        m_orig_x = ORIG_X_RST;
        m_orig_y = ORIG_Y_RST;
        lay_grid();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at reset settings
        foreach (table_rows[i])
            issue_cmd(table_rows[i].act, table_rows[i].dt, table_rows[i].idx,
                      table_rows[i].lit, table_rows[i].res);
        drain_results();

        // Strong gravity, no relaxation, tightest lattice at the origin
        cfg_write(CFG_GRAVITY, 29'd65536000);
        cfg_write(CFG_PASSES, 29'd0);
        cfg_write(CFG_SPACING, 29'd65536);
        cfg_write(CFG_ORIG_X, 29'd0);
        cfg_write(CFG_ORIG_Y, 29'd0);
        random_cmds(60, 40);
        drain_results();

        // No gravity, most passes, widest lattice at far origin: no steps here
        cfg_write(CFG_GRAVITY, 29'd0);
        cfg_write(CFG_PASSES, 29'd15);
        cfg_write(CFG_SPACING, 29'd6553600);
        cfg_write(CFG_ORIG_X, 29'd268435456);
        cfg_write(CFG_ORIG_Y, 29'd268435456);
        cfg_write(CFG_UNUSED, 29'($urandom));
        random_cmds(12, 0);
        drain_results();

        // Random settings, one relaxation pass
        cfg_write(CFG_GRAVITY, 29'($urandom_range(0, 65536000)));
        cfg_write(CFG_PASSES, 29'd1);
        cfg_write(CFG_SPACING, 29'($urandom_range(65536, 6553600)));
        cfg_write(CFG_ORIG_X, 29'($urandom_range(0, 268435456)));
        cfg_write(CFG_ORIG_Y, 29'($urandom_range(0, 268435456)));
        issue_cmd(ACT_REBUILD, 11'd0, 8'd0, 1'b0, table_rows[0].res);
        random_cmds(30, 15);
        drain_results();

        $display("ran %0d steps, %0d reads, %0d rebuilds, %0d unused commands",
                 n_step, n_read, n_rebuild, n_none);
        $display("checked %0d results over four register settings, %0d mismatches",
                 checked, errors);
        if (errors == 0 && pending_points.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
